### sv/frc_pkg.sv
// Shared types and constants of the frame receiver with XOR checksum.
package frc_pkg;

  localparam int ByteW   = 8;
  localparam int StatusW = 2;

  typedef logic [ByteW-1:0]   byte_t;
  typedef logic [StatusW-1:0] status_t;

  localparam status_t STATUS_GOOD     = 2'd0;
  localparam status_t STATUS_CHECKSUM = 2'd1;
  localparam status_t STATUS_LENGTH   = 2'd2;

  // Indexes of the configuration registers.
  localparam logic REG_START_MARKER = 1'b0;
  localparam logic REG_END_MARKER   = 1'b1;

  // Control of the shared checksum unit.
  typedef struct packed {
    logic clear;
    logic acc_en;
  } xor_ctl_t;

endpackage

### sv/frc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module frc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### sv/frc_xor.sv
// Shared checksum unit: XOR accumulator and compare against a stored byte.
module frc_xor (
  input  logic             clk,
  input  frc_pkg::xor_ctl_t ctl,
  input  frc_pkg::byte_t   data,
  output logic             match
);
  import frc_pkg::*;

  byte_t acc;

  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      acc <= '0;
    end else if (ctl.acc_en) begin
      acc <= acc ^ data;
    end
  end

  assign match = (acc == data);

endmodule

### sv/frame_receiver_xor_checksum.sv
// Frame receiver: collects start/end delimited frames, checks the XOR checksum, emits results.
// A received word that does not close a frame is taken without holding the input. A closing
// word with the right length starts a checksum walk over the frame store, one entry per cycle
// through the single read port of the store and the shared XOR unit, then emits the frame word
// by word: each word is read from the store again and loaded into the output register before
// the next is read, and output stall holds the emission. A closing word with the wrong length
// holds the input while its error word is loaded; a checksum error is loaded from the same
// error state after the walk. No word is taken while a walk or an emission is under way.
module frame_receiver_xor_checksum #(
  parameter int FRAME_LEN = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_wr_en,
  input  logic             cfg_index,
  input  frc_pkg::byte_t   cfg_data,
  input  logic             in_valid,
  output logic             in_stall,
  input  frc_pkg::byte_t   rx_byte,
  output logic             out_valid,
  input  logic             out_stall,
  output frc_pkg::byte_t   out_byte,
  output logic             out_last,
  output frc_pkg::status_t frame_status
);
  import frc_pkg::*;

  localparam int AW = $clog2(FRAME_LEN);
  localparam int CW = $clog2(FRAME_LEN + 1);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_WALK    = 3'd1;
  localparam logic [2:0] S_EMIT_RD = 3'd2;
  localparam logic [2:0] S_EMIT_WR = 3'd3;
  localparam logic [2:0] S_ERR     = 3'd4;

  logic [2:0]    state, state_next;
  logic          in_frame, in_frame_next;
  logic [CW-1:0] fill, fill_next;
  logic [CW-1:0] iss, iss_next;
  logic          dv, dv_next;
  logic [AW-1:0] di;
  logic [AW-1:0] emit_cnt, emit_cnt_next;
  status_t       err_status, err_status_next;
  byte_t         start_marker, end_marker;

  logic          in_acc, out_free, out_load;
  byte_t         load_byte;
  logic          load_last;
  status_t       load_status;

  logic          we, re, walk_re;
  logic [AW-1:0] waddr, raddr;
  byte_t         rdata;
  xor_ctl_t      xctl;
  logic          match;

  assign in_stall = (state != S_IDLE);
  assign in_acc   = in_valid & ~in_stall;
  assign out_free = ~out_valid | ~out_stall;
  assign walk_re  = (state == S_WALK) && (iss <= CW'(FRAME_LEN - 2));
  assign re       = walk_re || (state == S_EMIT_RD);
  assign raddr    = (state == S_WALK) ? iss[AW-1:0] : emit_cnt;

  frc_ram #(.WIDTH(ByteW), .DEPTH(FRAME_LEN)) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (rx_byte),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  frc_xor u_xor (
    .clk   (clk),
    .ctl   (xctl),
    .data  (rdata),
    .match (match)
  );

  always_comb begin
    state_next      = state;
    in_frame_next   = in_frame;
    fill_next       = fill;
    iss_next        = iss;
    emit_cnt_next   = emit_cnt;
    err_status_next = err_status;
    dv_next         = walk_re;
    we              = 1'b0;
    waddr           = fill[AW-1:0];
    xctl.clear      = 1'b0;
    xctl.acc_en     = dv && (di < AW'(FRAME_LEN - 2));
    out_load        = 1'b0;
    load_byte       = '0;
    load_last       = 1'b1;
    load_status     = STATUS_GOOD;

    case (state)
      S_IDLE: begin
        if (in_acc) begin
          if (!in_frame) begin
            if (rx_byte == start_marker) begin
              we            = 1'b1;
              waddr         = '0;
              in_frame_next = 1'b1;
              fill_next     = CW'(1);
            end
          end else if (rx_byte != end_marker) begin
            if (fill < CW'(FRAME_LEN)) begin
              we        = 1'b1;
              fill_next = fill + CW'(1);
            end
          end else begin
            in_frame_next = 1'b0;
            fill_next     = '0;
            if (fill == CW'(FRAME_LEN - 1)) begin
              we         = 1'b1;
              waddr      = AW'(FRAME_LEN - 1);
              iss_next   = '0;
              xctl.clear = 1'b1;
              state_next = S_WALK;
            end else begin
              err_status_next = STATUS_LENGTH;
              state_next      = S_ERR;
            end
          end
        end
      end
      S_WALK: begin
        if (walk_re) begin
          iss_next = iss + CW'(1);
        end
        // The word at the checksum position arrives after all summed words.
        if (dv && (di == AW'(FRAME_LEN - 2))) begin
          if (match) begin
            emit_cnt_next = '0;
            state_next    = S_EMIT_RD;
          end else begin
            err_status_next = STATUS_CHECKSUM;
            state_next      = S_ERR;
          end
        end
      end
      S_EMIT_RD: begin
        state_next = S_EMIT_WR;
      end
      S_EMIT_WR: begin
        if (out_free) begin
          out_load  = 1'b1;
          load_byte = rdata;
          load_last = (emit_cnt == AW'(FRAME_LEN - 1));
          if (load_last) begin
            state_next = S_IDLE;
          end else begin
            emit_cnt_next = emit_cnt + AW'(1);
            state_next    = S_EMIT_RD;
          end
        end
      end
      S_ERR: begin
        if (out_free) begin
          out_load    = 1'b1;
          load_status = err_status;
          state_next  = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      in_frame     <= 1'b0;
      fill         <= '0;
      dv           <= 1'b0;
      out_valid    <= 1'b0;
      start_marker <= '0;
      end_marker   <= '1;
    end else begin
      state     <= state_next;
      in_frame  <= in_frame_next;
      fill      <= fill_next;
      dv        <= dv_next;
      out_valid <= out_load | (out_valid & out_stall);
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_START_MARKER: start_marker <= cfg_data;
          REG_END_MARKER:   end_marker   <= cfg_data;
          default:          ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    iss        <= iss_next;
    di         <= iss[AW-1:0];
    emit_cnt   <= emit_cnt_next;
    err_status <= err_status_next;
    if (out_load) begin
      out_byte     <= load_byte;
      out_last     <= load_last;
      frame_status <= load_status;
    end
  end

endmodule

### verif/frame_receiver_xor_checksum_tb.sv
// Testbench of the frame receiver: drives delimited frames and checks every output word.
module frame_receiver_xor_checksum_tb;
  import frc_pkg::*;

  localparam int FRAME_LEN = 8;
  localparam int SETTLE_CYCLES = 2 * FRAME_LEN + 8;
  localparam int unsigned WORDS_PER_PHASE = 32;

  typedef enum int {
    KIND_GOOD, KIND_BAD_SUM, KIND_SHORT, KIND_LONG, KIND_CUT, KIND_NOISE
  } frame_kind_e;

  typedef struct {
    byte_t   data;
    logic    last;
    status_t status;
  } out_word_t;

  typedef byte_t word_q_t[$];

  class frame_predictor;
    byte_t       start_marker;
    byte_t       end_marker;
    byte_t       store[FRAME_LEN];
    bit          frame_open;
    int unsigned fill;
    out_word_t   due[$];
    int unsigned mismatches;

    function new();
      start_marker = 8'h00;
      end_marker = 8'hFF;
      frame_open = 1'b0;
      fill = 0;
      mismatches = 0;
    endfunction

    function void set_marker(logic idx, byte_t value);
      case (idx)
        REG_START_MARKER: start_marker = value;
        REG_END_MARKER: end_marker = value;
        default: ;
      endcase
    endfunction

    function void add_due(byte_t d, logic l, status_t s);
      out_word_t w;
      w.data = d;
      w.last = l;
      w.status = s;
      due.push_back(w);
    endfunction

    // Returns 1 when the word is taken into a frame, 0 when it is ignored.
    function bit take_rx_byte(byte_t b);
      byte_t sum;
      if (!frame_open) begin
        if (b == start_marker) begin
          frame_open = 1'b1;
          store[0] = b;
          fill = 1;
          return 1'b1;
        end
        return 1'b0;
      end
      if (b != end_marker) begin
        // An over-long frame stops filling the store but stays open.
        if (fill < FRAME_LEN) begin
          store[fill] = b;
          fill++;
        end
        return 1'b1;
      end
      frame_open = 1'b0;
      if (fill != FRAME_LEN - 1) begin
        fill = 0;
        add_due(8'h00, 1'b1, STATUS_LENGTH);
        return 1'b1;
      end
      store[FRAME_LEN-1] = b;
      fill = 0;
      sum = 8'h00;
      for (int i = 0; i < FRAME_LEN - 2; i++) sum ^= store[i];
      if (sum != store[FRAME_LEN-2]) begin
        add_due(8'h00, 1'b1, STATUS_CHECKSUM);
        return 1'b1;
      end
      for (int i = 0; i < FRAME_LEN; i++) add_due(store[i], i == FRAME_LEN - 1, STATUS_GOOD);
      return 1'b1;
    endfunction

    function void check_result(byte_t d, logic l, status_t s);
      out_word_t w;
      if (due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("output word with none expected: byte %02h last %0b status %0d", d, l, s);
        return;
      end
      w = due.pop_front();
      if (w.data !== d || w.last !== l || w.status !== s) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected %02h/%0b/%0d (byte/last/status), got %02h/%0b/%0d",
                   w.data, w.last, w.status, d, l, s);
      end
    endfunction
  endclass

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    cfg_wr_en = 1'b0;
  logic    cfg_index = REG_START_MARKER;
  byte_t   cfg_data = 8'h00;
  logic    in_valid = 1'b0;
  logic    in_stall;
  byte_t   rx_byte = 8'h00;
  logic    out_valid;
  logic    out_stall = 1'b0;
  byte_t   out_byte;
  logic    out_last;
  status_t frame_status;

  int unsigned gap_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned stall_left = 0;
  bit          quiet = 1'b0;
  frame_predictor pred;

  frame_receiver_xor_checksum #(.FRAME_LEN(FRAME_LEN)) u_dut (
    .clk(clk),
    .rst(rst),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .rx_byte(rx_byte),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_byte(out_byte),
    .out_last(out_last),
    .frame_status(frame_status)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Output side: check accepted words and stall in random bursts.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) pred.check_result(out_byte, out_last, frame_status);
    if (stall_left != 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
      stall_left = $urandom_range(0, 18);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  function automatic byte_t pick_data(byte_t en);
    byte_t b;
    do b = byte_t'($urandom); while (b == en);
    return b;
  endfunction

  function automatic word_q_t build_frame(frame_kind_e kind, byte_t st, byte_t en);
    word_q_t q;
    byte_t   sum;
    byte_t   b;
    int      n;
    q.push_back(st);
    sum = st;
    case (kind)
      KIND_GOOD, KIND_BAD_SUM: begin
        for (int i = 1; i < FRAME_LEN - 2; i++) begin
          q.push_back(pick_data(en));
          sum ^= q[i];
        end
        q.push_back(kind == KIND_GOOD ? sum : sum ^ byte_t'($urandom_range(1, 255)));
        q.push_back(en);
      end
      KIND_SHORT: begin
        n = $urandom_range(0, FRAME_LEN - 3);
        repeat (n) q.push_back(pick_data(en));
        q.push_back(en);
      end
      KIND_LONG: begin
        n = $urandom_range(FRAME_LEN - 1, FRAME_LEN + 3);
        repeat (n) q.push_back(pick_data(en));
        q.push_back(en);
      end
      KIND_CUT: begin
        // Left open on purpose: the next frame's words land in this one.
        n = $urandom_range(1, FRAME_LEN);
        repeat (n) q.push_back(pick_data(en));
      end
      default: begin
        q.delete();
        n = $urandom_range(1, 4);
        repeat (n) begin
          do b = byte_t'($urandom); while (b == st);
          q.push_back(b);
        end
      end
    endcase
    return q;
  endfunction

  task automatic send_word(input byte_t b, output bit taken);
    if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte <= b;
    do @(posedge clk); while (in_stall);
    taken = pred.take_rx_byte(b);
  endtask

  task automatic send_frame(input word_q_t q, inout int unsigned taken_count);
    bit taken;
    foreach (q[i]) begin
      send_word(q[i], taken);
      if (taken) taken_count++;
    end
  endtask

  // Hold the sender until every expected word is out and the block has settled.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pred.due.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_markers(input byte_t st, input byte_t en);
    drain();
    cfg_wr_en <= 1'b1;
    cfg_index <= REG_START_MARKER;
    cfg_data <= st;
    @(posedge clk);
    cfg_index <= REG_END_MARKER;
    cfg_data <= en;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    pred.set_marker(REG_START_MARKER, st);
    pred.set_marker(REG_END_MARKER, en);
  endtask

  task automatic run_random(input int unsigned target);
    int unsigned taken_count;
    int          r;
    frame_kind_e kind;
    taken_count = 0;
    while (taken_count < target) begin
      if (quiet) begin
        gap_pct = 0;
        stall_pct = 0;
      end else if ($urandom_range(0, 3) == 0) begin
        gap_pct = $urandom_range(0, 1) ? 0 : $urandom_range(5, 30);
        stall_pct = $urandom_range(0, 1) ? 0 : $urandom_range(5, 30);
      end
      r = $urandom_range(0, 99);
      if (r < 62) kind = KIND_GOOD;
      else if (r < 72) kind = KIND_BAD_SUM;
      else if (r < 80) kind = KIND_SHORT;
      else if (r < 88) kind = KIND_LONG;
      else if (r < 93) kind = KIND_CUT;
      else kind = KIND_NOISE;
      send_frame(build_frame(kind, pred.start_marker, pred.end_marker), taken_count);
      if (!quiet && $urandom_range(0, 9) == 0) drain();
    end
  endtask

  initial begin
    int unsigned dummy;
    // Ignored word, good frame with a start byte as data, bad checksum, short frame,
    // over-long frame that saturates the store.
    word_q_t directed = '{
      8'h55,
      8'h00, 8'h00, 8'h7F, 8'h80, 8'hFE, 8'h01, 8'h00, 8'hFF,
      8'h00, 8'h11, 8'h22, 8'h33, 8'h44, 8'h55, 8'hEE, 8'hFF,
      8'h00, 8'hFF,
      8'h00, 8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06, 8'h07, 8'h08, 8'hFF
    };
    pred = new();
    dummy = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    gap_pct = 15;
    stall_pct = 15;
    send_frame(directed, dummy);
    run_random(WORDS_PER_PHASE);
    write_markers(8'hFF, 8'h00);
    run_random(WORDS_PER_PHASE);
    // Equal markers: the same word opens and closes a frame.
    write_markers(8'h7E, 8'h7E);
    run_random(WORDS_PER_PHASE);
    write_markers(byte_t'($urandom), byte_t'($urandom));
    quiet = 1'b1;
    run_random(WORDS_PER_PHASE);
    drain();
    if (pred.mismatches == 0 && pred.due.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #(20 * 400_000);
    $display("FAILURE");
    $finish;
  end

endmodule
